### hdl/bsf_pkg.sv
package bsf_pkg;

  // Number of bytes in the longest frame and the width of a byte count.
  localparam int unsigned FRAME_BYTES_MAX = 10;
  localparam int unsigned COUNT_W         = $clog2(FRAME_BYTES_MAX + 1);

  localparam logic [7:0]  HEADER_BYTE     = 8'h55;
  localparam logic [7:0]  CMD_MOVE_TO     = 8'h01;
  localparam logic [7:0]  CMD_MODE        = 8'h1D;
  localparam logic [7:0]  CMD_TORQUE      = 8'h1F;

  // Angle limit in 1/16 degree (240 degrees) and motor speed limit.
  localparam logic [11:0] ANGLE_MAX       = 12'd3840;
  localparam logic signed [15:0] SPEED_LIMIT = 16'sd1000;

  localparam logic [15:0] MOVE_TIME_RESET = 16'd100;

  // Reciprocal of three scaled by 2^13, exact for dividends below 8192.
  localparam logic [11:0] RECIP_THREE     = 12'd2731;
  localparam int unsigned RECIP_SHIFT     = 13;

  typedef enum logic [1:0] {
    OP_MOVE   = 2'd0,
    OP_MOTOR  = 2'd1,
    OP_SERVO  = 2'd2,
    OP_TORQUE = 2'd3
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [7:0]         servo_id;
    logic signed [15:0] angle;
    logic signed [15:0] speed;
  } cmd_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
  } res_t;

  // A complete frame: byte 0 is sent first.
  typedef struct packed {
    logic [FRAME_BYTES_MAX-1:0][7:0] bytes;
    logic [COUNT_W-1:0]              count;
  } frame_t;

endpackage

### hdl/bsf_builder.sv
module bsf_builder (
  input  bsf_pkg::cmd_t   cmd,
  input  logic [15:0]     move_time,
  output bsf_pkg::frame_t frame
);
  import bsf_pkg::*;

  logic [11:0]        angle_clamped;
  logic [16:0]        angle_scaled;
  logic [23:0]        pos_product;
  logic [15:0]        pos;
  logic signed [15:0] speed_clamped;

  // pos = floor(a * 25 / 96) = floor(floor(a * 25 / 32) / 3).
  always_comb begin
    if (cmd.angle[15]) begin
      angle_clamped = '0;
    end else if (cmd.angle > $signed({4'b0000, ANGLE_MAX})) begin
      angle_clamped = ANGLE_MAX;
    end else begin
      angle_clamped = cmd.angle[11:0];
    end
    angle_scaled = 17'(angle_clamped) * 17'd25;
    pos_product  = 24'(angle_scaled[16:5]) * 24'(RECIP_THREE);
    pos          = 16'(pos_product[23:RECIP_SHIFT]);
  end

  always_comb begin
    if (cmd.speed < -SPEED_LIMIT) begin
      speed_clamped = -SPEED_LIMIT;
    end else if (cmd.speed > SPEED_LIMIT) begin
      speed_clamped = SPEED_LIMIT;
    end else begin
      speed_clamped = cmd.speed;
    end
  end

  always_comb begin
    logic [7:0] code;
    logic [7:0] len;
    logic [3:0][7:0] par;
    logic [7:0] sum;

    par = '0;
    unique case (cmd.operation)
      OP_MOVE: begin
        code = CMD_MOVE_TO;
        par  = {move_time[15:8], move_time[7:0], pos[15:8], pos[7:0]};
      end
      OP_MOTOR: begin
        code = CMD_MODE;
        par  = {speed_clamped[15:8], speed_clamped[7:0], 8'd0, 8'd1};
      end
      OP_SERVO: begin
        code = CMD_MODE;
      end
      OP_TORQUE: begin
        code = CMD_TORQUE;
        par  = {8'd0, 8'd0, 8'd0, 8'd1};
      end
      default: begin
        code = CMD_TORQUE;
      end
    endcase
    len = (cmd.operation == OP_TORQUE) ? 8'd4 : 8'd7;

    // Unused parameter slots are zero, so they do not disturb the sum.
    sum = cmd.servo_id + len + code + par[0] + par[1] + par[2] + par[3];

    frame.bytes[0] = HEADER_BYTE;
    frame.bytes[1] = HEADER_BYTE;
    frame.bytes[2] = cmd.servo_id;
    frame.bytes[3] = len;
    frame.bytes[4] = code;
    frame.bytes[5] = par[0];
    frame.bytes[6] = par[1];
    frame.bytes[7] = par[2];
    frame.bytes[8] = par[3];
    frame.bytes[9] = ~sum;
    frame.count    = COUNT_W'(FRAME_BYTES_MAX);
    if (cmd.operation == OP_TORQUE) begin
      frame.bytes[6] = ~sum;
      frame.count    = COUNT_W'(FRAME_BYTES_MAX - 3);
    end
  end

endmodule

### hdl/bsf_serializer.sv
module bsf_serializer (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  bsf_pkg::frame_t frame,
  output logic            ending,
  output logic            strobe,
  output bsf_pkg::res_t   result
);
  import bsf_pkg::*;

  logic [FRAME_BYTES_MAX-1:0][7:0] shift;
  logic [COUNT_W-1:0]              remaining;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load) begin
      remaining <= frame.count;
    end else if (remaining != '0) begin
      remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift <= frame.bytes;
    end else begin
      shift <= {8'h00, shift[FRAME_BYTES_MAX-1:1]};
    end
  end

  // The serializer can take a new frame in the cycle its last byte goes out.
  assign ending            = (remaining <= COUNT_W'(1));
  assign strobe            = (remaining != '0);
  assign result.frame_byte = shift[0];
  assign result.last       = (remaining == COUNT_W'(1));

endmodule

### hdl/bus_servo_command_framer.sv
// An accepted request goes into the command register and is then loaded into
// the serializer when it is free, which puts the first byte of its frame on
// the result ports; bytes follow one per cycle. One command goes out per frame
// of ten bytes (seven for torque enable), set by the serializer's byte rate.
// Reset (rst, synchronous) empties the command register and the serializer
// and sets move_time to 100. The receiver cannot stall the result stream.
module bus_servo_command_framer (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  bsf_pkg::cmd_t   command,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [15:0]     cfg_data,
  output logic            strobe,
  output bsf_pkg::res_t   result
);
  import bsf_pkg::*;

  // The command register holds one request while the serializer finishes the
  // previous frame, so a new request is taken while bytes are still going out.
  cmd_t        cmd_reg;
  logic        cmd_valid;
  logic [15:0] move_time;
  frame_t      frame;
  logic        ending;
  logic        load;
  logic        accept;

  // The frame is built from the command register and handed to the
  // serializer as soon as it is empty or sending its final byte.
  assign load   = cmd_valid && ending;
  assign busy   = cmd_valid && !ending;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (load) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_reg <= command;
    end
  end

  // The move time register is always ready for a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_time <= MOVE_TIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      move_time <= cfg_data;
    end
  end

  bsf_builder u_builder (
    .cmd       (cmd_reg),
    .move_time (move_time),
    .frame     (frame)
  );

  bsf_serializer u_serializer (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .frame  (frame),
    .ending (ending),
    .strobe (strobe),
    .result (result)
  );

endmodule

### tb/tb_bus_servo_command_framer.sv
module tb_bus_servo_command_framer;

  import bsf_pkg::*;

  // Frame constants of the serial servo bus, kept local so that the expected
  // frames do not lean on the design's own package values.
  localparam logic [7:0]  FRAME_HEADER   = 8'h55;
  localparam logic [7:0]  CODE_MOVE      = 8'h01;
  localparam logic [7:0]  CODE_MODE      = 8'h1D;
  localparam logic [7:0]  CODE_TORQUE    = 8'h1F;
  localparam int          ANGLE_TOP      = 3840;
  localparam int          SPEED_TOP      = 1000;
  localparam logic [15:0] MOVE_TIME_INIT = 16'd100;

  // Cycles without any request, configuration write or frame byte before the
  // run is declared hung. The slowest legitimate gap is a long run of sender
  // idling, which at 73 in a hundred stays far below this figure.
  localparam int STALL_LIMIT = 1000;

  // A queued request, optionally held back until every byte already due has
  // been seen on the result port.
  typedef struct {
    cmd_t cmd;
    bit   drain_first;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t command = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;
  logic strobe;
  res_t result;

  pending_t    cmd_backlog[$];
  res_t        bytes_due[$];
  logic [15:0] move_time_copy = MOVE_TIME_INIT;
  bit          req_taken = 1'b0;
  int          idle_pct = 0;
  int          quiet_cycles = 0;
  bit          failed = 1'b0;

  bus_servo_command_framer dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .result    (result)
  );

  always #1 clk = ~clk;

  // Works out the whole frame that one command must produce and appends its
  // bytes, in bus order, to the store of bytes still due. The checksum is the
  // inverted low byte of the sum from the id through the last parameter.
  function automatic void frame_for_command(cmd_t c);
    logic [7:0]  bytes [10];
    logic [7:0]  params [4];
    logic [7:0]  code;
    logic [7:0]  sum;
    logic [15:0] word;
    int          n_params;
    int          ang;
    int          spd;
    int          pos;
    int          count;
    res_t        r;
    params = '{8'd0, 8'd0, 8'd0, 8'd0};
    case (c.operation)
      OP_MOVE: begin
        // Angle in sixteenths of a degree, saturated to 0..240 degrees and
        // scaled so that the full span maps onto 0..1000.
        ang = c.angle;
        if (ang < 0) ang = 0;
        if (ang > ANGLE_TOP) ang = ANGLE_TOP;
        pos = (ang * 25) / 96;
        word = pos[15:0];
        code = CODE_MOVE;
        params = '{word[7:0], word[15:8], move_time_copy[7:0], move_time_copy[15:8]};
        n_params = 4;
      end
      OP_MOTOR: begin
        spd = c.speed;
        if (spd < -SPEED_TOP) spd = -SPEED_TOP;
        if (spd > SPEED_TOP) spd = SPEED_TOP;
        word = spd[15:0];
        code = CODE_MODE;
        params = '{8'd1, 8'd0, word[7:0], word[15:8]};
        n_params = 4;
      end
      OP_SERVO: begin
        code = CODE_MODE;
        n_params = 4;
      end
      default: begin
        code = CODE_TORQUE;
        params[0] = 8'd1;
        n_params = 1;
      end
    endcase
    bytes[0] = FRAME_HEADER;
    bytes[1] = FRAME_HEADER;
    bytes[2] = c.servo_id;
    bytes[3] = 8'(n_params + 3);
    bytes[4] = code;
    sum = c.servo_id + bytes[3] + code;
    for (int i = 0; i < n_params; i++) begin
      bytes[5 + i] = params[i];
      sum = sum + params[i];
    end
    bytes[5 + n_params] = ~sum;
    count = 6 + n_params;
    for (int i = 0; i < count; i++) begin
      r.frame_byte = bytes[i];
      r.last = (i == count - 1);
      bytes_due.push_back(r);
    end
  endfunction

  // Random command: values inside the clamping windows are favoured, with a
  // share of saturating values on both sides and fully random words.
  function automatic cmd_t random_command();
    cmd_t c;
    c.operation = op_t'($urandom_range(3));
    c.servo_id = 8'($urandom_range(255));
    case ($urandom_range(7))
      0, 1, 2: c.angle = 16'($urandom_range(ANGLE_TOP));
      3:       c.angle = 16'($urandom_range(32767, ANGLE_TOP + 1));
      4:       c.angle = 16'(-$urandom_range(32768, 1));
      5:       c.angle = 16'($urandom_range(ANGLE_TOP + 2, ANGLE_TOP - 2));
      default: c.angle = 16'($urandom);
    endcase
    case ($urandom_range(7))
      0, 1, 2: c.speed = 16'($urandom_range(2 * SPEED_TOP) - SPEED_TOP);
      3:       c.speed = 16'($urandom_range(32767, SPEED_TOP + 1));
      4:       c.speed = 16'(-$urandom_range(32768, SPEED_TOP + 1));
      5:       c.speed = 16'($urandom_range(SPEED_TOP + 2, SPEED_TOP - 2));
      default: c.speed = 16'($urandom);
    endcase
    return c;
  endfunction

  task automatic queue_cmd(op_t op, int id, int ang, int spd, bit drain);
    pending_t p;
    p.cmd.operation = op;
    p.cmd.servo_id = 8'(id);
    p.cmd.angle = 16'(ang);
    p.cmd.speed = 16'(spd);
    p.drain_first = drain;
    cmd_backlog.push_back(p);
  endtask

  // Waits until every request has been taken and every byte due has arrived,
  // then lets the serializer settle.
  task automatic wait_until_quiet();
    do @(negedge clk); while (cmd_backlog.size() != 0 || bytes_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // The register is only written with the block idle, so the copy used for
  // prediction can never change under a frame being built.
  task automatic write_move_time(logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(int n);
    pending_t p;
    for (int i = 0; i < n; i++) begin
      p.cmd = random_command();
      // Now and then the sender holds its request until the result stream has
      // gone completely quiet.
      p.drain_first = ($urandom_range(24) == 0);
      cmd_backlog.push_back(p);
    end
  endtask

  // Driver. A request that has been raised stays up, unchanged, until the
  // edge that takes it; only then is the next one considered. Each decision is
  // a single assignment per signal on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !req_taken)) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct &&
          !(cmd_backlog[0].drain_first && (bytes_due.size() != 0 || busy))) begin
        start <= 1'b1;
        command <= cmd_backlog[0].cmd;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. On every rising edge it notes a taken request and predicts its
  // frame, follows register writes, checks each frame byte against the oldest
  // byte due, and keeps the watchdog running.
  always @(posedge clk) begin
    pending_t head;
    res_t     want;
    bit       progress;
    progress = 1'b0;
    req_taken <= start && !busy && !rst;
    if (rst) begin
      move_time_copy = MOVE_TIME_INIT;
      quiet_cycles = 0;
    end else begin
      if (start && !busy) begin
        head = cmd_backlog.pop_front();
        frame_for_command(head.cmd);
        progress = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        move_time_copy = cfg_data;
        progress = 1'b1;
      end
      if (strobe) begin
        progress = 1'b1;
        if (bytes_due.size() == 0) begin
          $display("%0t: unexpected frame byte, expected none, got byte %02h last %0b",
                   $time, result.frame_byte, result.last);
          failed = 1'b1;
        end else begin
          want = bytes_due.pop_front();
          if (result.frame_byte !== want.frame_byte) begin
            $display("%0t: frame byte mismatch, expected %02h, got %02h",
                     $time, want.frame_byte, result.frame_byte);
            failed = 1'b1;
          end
          if (result.last !== want.last) begin
            $display("%0t: last flag mismatch, expected %0b, got %0b",
                     $time, want.last, result.last);
            failed = 1'b1;
          end
        end
      end
      if (progress) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no activity for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, run with the reset value of move_time so that it is
    // checked before any write. It covers every operation, both ends of the
    // id, the angle and speed either side of their clamping bounds, and the
    // fields that a command must ignore carrying odd values.
    idle_pct = 0;
    queue_cmd(OP_MOVE,     0,      0,      0, 1'b0);
    queue_cmd(OP_MOVE,   255,   3840,  -1000, 1'b0);
    queue_cmd(OP_MOVE,     1,   3841,  32767, 1'b0);
    queue_cmd(OP_MOVE,     2,  32767, -32768, 1'b0);
    queue_cmd(OP_MOVE,     3,     -1,      0, 1'b0);
    queue_cmd(OP_MOVE,     4, -32768,      0, 1'b0);
    queue_cmd(OP_MOVE,     5,     95,      0, 1'b0);
    queue_cmd(OP_MOVE,     6,     96,      0, 1'b0);
    queue_cmd(OP_MOVE,     7,   3839,      0, 1'b0);
    queue_cmd(OP_MOTOR,    0,  32767,      0, 1'b0);
    queue_cmd(OP_MOTOR,  255, -32768,   1000, 1'b0);
    queue_cmd(OP_MOTOR,    8,      0,   1001, 1'b0);
    queue_cmd(OP_MOTOR,    9,      0,  32767, 1'b0);
    queue_cmd(OP_MOTOR,   10,      0,  -1000, 1'b0);
    queue_cmd(OP_MOTOR,   11,      0,  -1001, 1'b0);
    queue_cmd(OP_MOTOR,   12,      0, -32768, 1'b0);
    queue_cmd(OP_MOTOR,   13,      0,     -1, 1'b0);
    queue_cmd(OP_MOTOR,   14,      0,      1, 1'b0);
    queue_cmd(OP_SERVO,    0,  -1234,  32767, 1'b0);
    queue_cmd(OP_SERVO,  255,   3840,     -1, 1'b1);
    queue_cmd(OP_TORQUE,   0,     -1,     -1, 1'b0);
    queue_cmd(OP_TORQUE, 255,  32767, -32768, 1'b0);
    queue_cmd(OP_MOVE,   170,   1920,    555, 1'b0);
    wait_until_quiet();

    // Random phases, each under its own move_time and sender idling. The
    // receiver has no way to hold off bytes, so the phase meant for receiver
    // stalls runs with the sender busy all the time.
    write_move_time(16'h0000);
    idle_pct = 0;
    queue_random(50);
    wait_until_quiet();

    write_move_time(16'hFFFF);
    idle_pct = 73;
    queue_random(50);
    wait_until_quiet();

    write_move_time(16'($urandom));
    idle_pct = 0;
    queue_random(50);
    wait_until_quiet();

    write_move_time(16'($urandom));
    idle_pct = 30;
    queue_random(50);
    wait_until_quiet();

    // A further stretch so that a stray byte after the last frame is caught.
    repeat (12) @(negedge clk);
    if (!failed && bytes_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/bsf_pkg.sv
hdl/bsf_builder.sv
hdl/bsf_serializer.sv
hdl/bus_servo_command_framer.sv
tb/tb_bus_servo_command_framer.sv
